// ===== sv/sjt_pkg.sv =====
// Shared types and constants for the sinusoidal joint trajectory generator.
// Used by sjt_mul, sjt_cordic and the top level; depends on nothing.
package sjt_pkg;

    // joint count fixed by the result layout
    localparam int NJ   = 3;
    localparam int JW   = 2;
    localparam int AW   = 18;   // amplitude, unsigned Q2.16
    localparam int PW   = 32;   // phase, one turn = 2^32
    localparam int POSW = 20;
    localparam int VELW = 24;
    localparam int XW   = 34;   // CORDIC x/y, signed Q2.30 with headroom
    localparam int ZW   = 33;   // CORDIC residual angle
    localparam int MW   = 32;   // shared multiplier operand width
    localparam int PRW  = 2 * MW;
    localparam int OMW  = 37;   // omega, Q16 rad/s
    localparam int AVW  = 56;   // amplitude times omega, Q32

    localparam logic signed [XW-1:0] GAIN_Q30   = 34'sd652032874;
    localparam logic signed [XW:0]   ONE_Q30    = 35'sd1073741824;
    localparam logic [MW-1:0]        TWO_PI_Q29 = 32'd3373259426;

    localparam logic [AW-1:0] AMP0_RST  = 18'd25736;
    localparam logic [AW-1:0] AMP1_RST  = 18'd51472;
    localparam logic [AW-1:0] AMP2_RST  = 18'd51472;
    localparam logic [PW-1:0] STEP0_RST = 32'd2147484;
    localparam logic [PW-1:0] STEP1_RST = 32'd1431656;
    localparam logic [PW-1:0] STEP2_RST = 32'd1431656;

    // register map, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_AMP0  = 3'd0,
        REG_AMP1  = 3'd1,
        REG_AMP2  = 3'd2,
        REG_STEP0 = 3'd3,
        REG_STEP1 = 3'd4,
        REG_STEP2 = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic          start;
        logic [PW-1:0] phase;
    } t_cordic_req;

    typedef struct packed {
        logic                 done;
        logic signed [XW-1:0] cos_q;
        logic signed [XW-1:0] sin_q;
    } t_cordic_res;

    typedef struct packed {
        logic          en;
        logic [MW-1:0] a;
        logic [MW-1:0] b;
    } t_mul_req;

    // arctangent of 2^-i in turns * 2^32
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/sjt_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on sjt_pkg for the request struct and widths.
module sjt_mul (
    input  logic              i_clk,
    input  sjt_pkg::t_mul_req i_req,
    output logic [63:0]       o_prod
);
    import sjt_pkg::*;

    logic [PRW-1:0] r_prod;

    // product holds until the next issued request
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/sjt_cordic.sv =====
// Iterative rotation-mode CORDIC: one shift/add step per cycle, half-turn fold.
// Depends on sjt_pkg for the arctangent table, gain and structs.
module sjt_cordic #(
    parameter int ITERATIONS = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sjt_pkg::t_cordic_req i_req,
    output sjt_pkg::t_cordic_res o_res
);
    import sjt_pkg::*;

    localparam int N  = (ITERATIONS > 32) ? 32 : ITERATIONS;
    localparam int CW = $clog2(N);
    localparam logic [CW-1:0] LAST = CW'(N - 1);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_FIX  = 3'b100
    } t_cstate;

    t_cstate              r_state;
    logic                 r_done;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [CW-1:0]        r_i;
    logic                 r_flip;

    logic [PW-1:0]        w_plus;
    logic                 w_flip;
    logic [PW-1:0]        w_p;
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [ZW-1:0] w_atan;

    // fold phases in [1/4, 3/4) turn by a half turn
    assign w_plus = i_req.phase + 32'h4000_0000;
    assign w_flip = w_plus[PW-1];
    assign w_p    = w_flip ? (i_req.phase ^ 32'h8000_0000) : i_req.phase;

    // arithmetic shifts floor, as required
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_atan = $signed({1'b0, atan_turns(5'(r_i))});

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else if (i_req.start) begin
            r_state <= C_RUN;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            case (r_state)
                C_RUN: begin
                    if (r_i == LAST) begin
                        r_state <= C_FIX;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                C_FIX: begin
                    r_state <= C_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= GAIN_Q30;
            r_y    <= '0;
            r_z    <= $signed({w_p[PW-1], w_p});
            r_flip <= w_flip;
        end else if (r_state == C_RUN) begin
            if (!r_z[ZW-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end else if (r_state == C_FIX && r_flip) begin
            r_x <= -r_x;
            r_y <= -r_y;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cos_q = r_x;
    assign o_res.sin_q = r_y;

endmodule

// ===== sv/sinusoidal_joint_trajectory_generator_unit.sv =====
// Sinusoidal joint trajectory generator, top level: registers, sequencer, outputs.
// Depends on sjt_pkg, sjt_mul and sjt_cordic.
//
// Usage: each input item on the s_ channel is one control tick; s_tdata[0] is
// the advance flag. For every tick one result item leaves on the m_ channel with
// position A*(1-cos(phase)) and velocity A*omega*sin(phase) for three joints.
// Amplitudes and phase steps are set over the APB port; the user must set them
// only while idle, as the block itself does not enforce it. Joints are done one
// after another; per joint the work is the CORDIC iterations plus the multiply
// chain through the one shared multiplier. s_tready is high only in the idle
// state, so the block takes no new tick until the previous one is done.
// The result sits in an output register; a stalled receiver does not hold the
// block, which takes the next tick and only waits at the end if the previous
// result is still pending. Reset clears all phases to zero, loads the register
// defaults and empties the output register.
module sinusoidal_joint_trajectory_generator_unit #(
    parameter int JOINT_COUNT     = 3,
    parameter int TICK_RATE_HZ    = 1000,
    parameter int SINE_ITERATIONS = 18
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [0] advance, [7:1] zero
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [19:0] position_joint0, [39:20] position_joint1, [59:40] position_joint2,
    // [83:60] velocity_joint0, [107:84] velocity_joint1,
    // [131:108] velocity_joint2, [135:132] zero
    output logic [135:0] m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sjt_pkg::*;

    localparam int ACTIVE = (JOINT_COUNT < NJ) ? JOINT_COUNT : NJ;
    localparam logic [JW-1:0] LAST_J = JW'(ACTIVE - 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'h0001,
        S_START = 14'h0002,
        S_PI0   = 14'h0004,
        S_PI1   = 14'h0008,
        S_OM    = 14'h0010,
        S_AV0   = 14'h0020,
        S_AV1   = 14'h0040,
        S_AVS   = 14'h0080,
        S_WAITC = 14'h0100,
        S_V0    = 14'h0200,
        S_V1    = 14'h0400,
        S_PM    = 14'h0800,
        S_PS    = 14'h1000,
        S_DONE  = 14'h2000
    } t_state;

    t_state              r_state;
    logic [JW-1:0]       r_joint;
    logic                r_adv;
    logic [AW-1:0]       r_amp   [NJ];
    logic [PW-1:0]       r_step  [NJ];
    logic [PW-1:0]       r_phase [NJ];
    logic [16:0]         r_a1;
    logic [PRW-1:0]      r_lo;
    logic [PRW-1:0]      r_hi;
    logic [OMW-1:0]      r_omega;
    logic [AVW-1:0]      r_av;
    logic [MW-1:0]       r_dmag;
    logic                r_dneg;
    logic [MW-1:0]       r_smag;
    logic                r_sneg;
    logic [POSW-1:0]     r_pos [NJ];
    logic [VELW-1:0]     r_vel [NJ];
    logic                r_mvalid;
    logic [135:0]        r_mdata;

    t_mul_req            w_mreq;
    logic [PRW-1:0]      w_prod;
    t_cordic_req         w_creq;
    t_cordic_res         w_cres;

    logic                w_s_acc;
    logic                w_m_free;
    logic                w_cfg_wr;
    t_reg_idx            w_idx;
    logic [PRW-1:0]      w_omsum;
    logic signed [XW:0]  w_d;
    logic signed [XW:0]  w_dabs;
    logic signed [XW-1:0] w_sabs;
    logic [PRW-1:0]      w_psum;
    logic [33:0]         w_pmag;
    logic [PRW-1:0]      w_vsum;
    logic [49:0]         w_vmag;
    logic [POSW-1:0]     w_pos;
    logic [VELW-1:0]     w_vel;

    assign w_s_acc  = s_tvalid && s_tready;
    assign w_m_free = !r_mvalid || m_tready;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_idx    = t_reg_idx'(paddr[4:2]);

    sjt_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_prod (w_prod)
    );

    sjt_cordic #(
        .ITERATIONS (SINE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_creq),
        .o_res   (w_cres)
    );

    assign w_creq.start = (r_state == S_START);
    assign w_creq.phase = r_phase[r_joint];

    // operand select for the shared multiplier
    always_comb begin
        w_mreq = '0;
        case (r_state)
            S_START: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = r_step[r_joint];
                w_mreq.b  = 32'(TICK_RATE_HZ);
            end
            S_PI0: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = w_prod[31:0];
                w_mreq.b  = TWO_PI_Q29;
            end
            S_PI1: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = {15'b0, r_a1};
                w_mreq.b  = TWO_PI_Q29;
            end
            S_AV0: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = r_omega[31:0];
                w_mreq.b  = {14'b0, r_amp[r_joint]};
            end
            S_AV1: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = {27'b0, r_omega[36:32]};
                w_mreq.b  = {14'b0, r_amp[r_joint]};
            end
            S_V0: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = r_av[31:0];
                w_mreq.b  = r_smag;
            end
            S_V1: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = {8'b0, r_av[55:32]};
                w_mreq.b  = r_smag;
            end
            S_PM: begin
                w_mreq.en = 1'b1;
                w_mreq.a  = r_dmag;
                w_mreq.b  = {14'b0, r_amp[r_joint]};
            end
            default: begin
                w_mreq = '0;
            end
        endcase
    end

    // omega = round(step * rate * 2pi / 2^45), high partial plus carried low half
    assign w_omsum = w_prod + r_lo + 64'd4096;

    // 1 - cos and |sin| from the CORDIC result
    assign w_d    = ONE_Q30 - {w_cres.cos_q[XW-1], w_cres.cos_q};
    assign w_dabs = w_d[XW] ? -w_d : w_d;
    assign w_sabs = w_cres.sin_q[XW-1] ? -w_cres.sin_q : w_cres.sin_q;

    // position: round |d|*A to Q16, restore sign, saturate
    assign w_psum = w_prod + 64'd536870912;
    assign w_pmag = w_psum[63:30];
    always_comb begin
        if (r_dneg) begin
            w_pos = (w_pmag >= 34'd524288) ? 20'h80000 : 20'(34'd0 - w_pmag);
        end else begin
            w_pos = (w_pmag >= 34'd524287) ? 20'h7FFFF : w_pmag[19:0];
        end
    end

    // velocity: round A*omega*|sin| to Q16, restore sign, saturate
    assign w_vsum = r_hi + 64'd8192;
    assign w_vmag = w_vsum[63:14];
    always_comb begin
        if (r_sneg) begin
            w_vel = (w_vmag >= 50'd8388608) ? 24'h800000 : 24'(50'd0 - w_vmag);
        end else begin
            w_vel = (w_vmag >= 50'd8388607) ? 24'h7FFFFF : w_vmag[23:0];
        end
    end

    // sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_joint  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            if (r_mvalid && m_tready && r_state != S_DONE) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_state <= S_START;
                        r_joint <= '0;
                    end
                end
                S_START: r_state <= S_PI0;
                S_PI0:   r_state <= S_PI1;
                S_PI1:   r_state <= S_OM;
                S_OM:    r_state <= S_AV0;
                S_AV0:   r_state <= S_AV1;
                S_AV1:   r_state <= S_AVS;
                S_AVS:   r_state <= S_WAITC;
                S_WAITC: begin
                    if (w_cres.done) begin
                        r_state <= S_V0;
                    end
                end
                S_V0:    r_state <= S_V1;
                S_V1:    r_state <= S_PM;
                S_PM:    r_state <= S_PS;
                S_PS: begin
                    if (r_joint == LAST_J) begin
                        r_state <= S_DONE;
                    end else begin
                        r_joint <= r_joint + 1'b1;
                        r_state <= S_START;
                    end
                end
                S_DONE: begin
                    if (w_m_free) begin
                        r_mvalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    r_adv <= s_tdata[0];
                    for (int j = 0; j < NJ; j++) begin
                        r_pos[j] <= '0;
                        r_vel[j] <= '0;
                    end
                end
            end
            S_PI0: r_a1 <= w_prod[48:32];
            S_PI1: r_lo <= {32'b0, w_prod[63:32]};
            S_OM:  r_omega <= w_omsum[49:13];
            S_AV1: r_lo <= w_prod;
            S_AVS: r_av <= AVW'(r_lo + {w_prod[31:0], 32'b0});
            S_WAITC: begin
                r_dmag <= w_dabs[31:0];
                r_dneg <= w_d[XW];
                r_smag <= w_sabs[31:0];
                r_sneg <= w_cres.sin_q[XW-1];
            end
            S_V1: r_lo <= {32'b0, w_prod[63:32]};
            S_PM: r_hi <= w_prod + r_lo;
            S_PS: begin
                r_pos[r_joint] <= w_pos;
                r_vel[r_joint] <= w_vel;
            end
            S_DONE: begin
                if (w_m_free) begin
                    r_mdata <= {4'b0, r_vel[2], r_vel[1], r_vel[0],
                                r_pos[2], r_pos[1], r_pos[0]};
                end
            end
            default: begin
                r_adv <= r_adv;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp[0]  <= AMP0_RST;
            r_amp[1]  <= AMP1_RST;
            r_amp[2]  <= AMP2_RST;
            r_step[0] <= STEP0_RST;
            r_step[1] <= STEP1_RST;
            r_step[2] <= STEP2_RST;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_AMP0:  r_amp[0]  <= pwdata[AW-1:0];
                REG_AMP1:  r_amp[1]  <= pwdata[AW-1:0];
                REG_AMP2:  r_amp[2]  <= pwdata[AW-1:0];
                REG_STEP0: r_step[0] <= pwdata;
                REG_STEP1: r_step[1] <= pwdata;
                REG_STEP2: r_step[2] <= pwdata;
                default: begin
                    r_step[0] <= r_step[0];
                end
            endcase
        end
    end

    // phase accumulators advance on an advancing tick as each joint's result is stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NJ; j++) begin
                r_phase[j] <= '0;
            end
        end else if (r_state == S_PS && r_adv) begin
            r_phase[r_joint] <= r_phase[r_joint] + r_step[r_joint];
        end
    end

    // register readback
    always_comb begin
        case (w_idx)
            REG_AMP0:  prdata = {14'b0, r_amp[0]};
            REG_AMP1:  prdata = {14'b0, r_amp[1]};
            REG_AMP2:  prdata = {14'b0, r_amp[2]};
            REG_STEP0: prdata = r_step[0];
            REG_STEP1: prdata = r_step[1];
            REG_STEP2: prdata = r_step[2];
            default:   prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;

    // a tick closes the input side until its work is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !s_tready)
        else $error("input accepted while a tick is in progress");

    // a result appears only from the final state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result valid raised outside the done state");

    // phases hold on a tick without advance
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PS && !r_adv) |=>
            ($stable(r_phase[0]) && $stable(r_phase[1]) && $stable(r_phase[2])))
        else $error("phase moved on a tick without advance");

    // the joint counter stays within the joints in use
    a_joint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_joint <= LAST_J))
        else $error("joint index beyond the joints in use");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the sinusoidal joint trajectory generator: ticks go in
// on the input stream and each result is compared with a local fixed-point model.
// Depends on sjt_pkg (register indexes) and the top level of the block.
`timescale 1ns / 100ps

module tb_top;
    import sjt_pkg::*;

    localparam int  NUM_JOINTS  = 3;
    localparam int  ROT_STEPS   = 18;          // CORDIC iterations of the block
    localparam int  TICK_HZ     = 1000;
    localparam longint ROT_GAIN = 64'sd652032874;
    localparam longint UNIT_Q30 = 64'sd1073741824;
    localparam logic [127:0] TWO_PI_Q29 = 128'd3373259426;
    localparam logic [17:0] AMP_MASK = 18'h3FFFF;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_CYCLES  = 96;        // a margin over the processing of one tick
    localparam int  LONG_HOLD     = 300;
    localparam int  STALL_LIMIT   = 2000;
    localparam int  RANDOM_SETS   = 8;
    localparam int  TICKS_PER_SET = 45;

    // register slots past the map, writes there must be dropped
    localparam logic [2:0] UNMAPPED_LO = 3'd6;
    localparam logic [2:0] UNMAPPED_HI = 3'd7;

    logic         i_clk     = 1'b0;
    logic         i_rst_n   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'd0;   // [0] advance, [7:1] zero
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // [19:0] pos0, [39:20] pos1, [59:40] pos2, [83:60] vel0, [107:84] vel1,
    // [131:108] vel2, [135:132] zero
    logic [135:0] m_tdata;
    logic         psel      = 1'b0;
    logic         penable   = 1'b0;
    logic         pwrite    = 1'b0;
    logic [4:0]   paddr     = 5'd0;
    logic [31:0]  pwdata    = 32'd0;
    logic [31:0]  prdata;
    logic         pready;

    sinusoidal_joint_trajectory_generator_unit u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // model state: settings and phase accumulators
    logic [17:0] amp_reg   [NUM_JOINTS];
    logic [31:0] step_reg  [NUM_JOINTS];
    logic [31:0] phase_acc [NUM_JOINTS];

    // arctangent of 2^-i in turns * 2^32
    longint atan_tab [0:ROT_STEPS-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215};

    logic [135:0] pending_targets [$];
    logic         idle_on       = 1'b1;
    logic         hold_off_req  = 1'b0;
    logic         hold_off_seen = 1'b0;
    int           stall_left    = 0;
    int           quiet_cycles  = 0;
    int           mismatches    = 0;
    int           ticks_sent    = 0;
    int           holds_sent    = 0;
    int           results_seen  = 0;
    int           reg_writes    = 0;

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // sine/cosine of a phase, half-turn fold then rotation-mode CORDIC (Q30)
    function automatic void rotate_phase(input logic [31:0] ph,
                                         output longint cosv, output longint sinv);
        logic        flip;
        logic [31:0] p;
        longint      x, y, z, dx, dy;
        int          i;
        flip = ph[31] ^ ph[30];
        p = flip ? ph + 32'h8000_0000 : ph;
        z = longint'($signed(p));
        x = ROT_GAIN;
        y = 0;
        for (i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab[i];
            end
        end
        cosv = flip ? -x : x;
        sinv = flip ? -y : y;
    endfunction

    // positions and velocities of all joints at the current phases, packed as m_tdata
    function automatic logic [135:0] joint_targets();
        logic [135:0] packed_out;
        logic [127:0] omega, amp_omega, vmag;
        longint       cosv, sinv, d, pmag, pos, vel, abs_s;
        int           j;
        packed_out = '0;
        for (j = 0; j < NUM_JOINTS; j++) begin
            rotate_phase(phase_acc[j], cosv, sinv);
            d = UNIT_Q30 - cosv;
            pmag = ((d < 0 ? -d : d) * longint'(amp_reg[j]) + (64'sd1 <<< 29)) >>> 30;
            pos = d < 0 ? -pmag : pmag;
            if (pos > 524287) pos = 524287;
            if (pos < -524288) pos = -524288;

            omega = 128'(step_reg[j]) * 128'(TICK_HZ) * TWO_PI_Q29;
            omega = (omega + (128'd1 << 44)) >> 45;
            amp_omega = omega * 128'(amp_reg[j]);
            abs_s = sinv < 0 ? -sinv : sinv;
            vmag = (amp_omega * 128'(abs_s) + (128'd1 << 45)) >> 46;
            vel = sinv < 0 ? -longint'(vmag[63:0]) : longint'(vmag[63:0]);
            if (vel > 8388607) vel = 8388607;
            if (vel < -8388608) vel = -8388608;

            packed_out[20*j +: 20] = pos[19:0];
            packed_out[60 + 24*j +: 24] = vel[23:0];
        end
        return packed_out;
    endfunction

    // one tick accepted: queue its result, then move the phases on
    task automatic record_tick(input logic adv);
        int j;
        pending_targets.push_back(joint_targets());
        if (adv) begin
            for (j = 0; j < NUM_JOINTS; j++)
                phase_acc[j] = phase_acc[j] + step_reg[j];
        end else begin
            holds_sent++;
        end
        ticks_sent++;
    endtask

    // offer one tick, sometimes with a random gap in front of it while gaps are on
    task automatic send_tick(input logic adv);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, adv};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        record_tick(adv);
    endtask

    // stop offering, let all results come back and the block settle
    task automatic wait_quiet(input int settle);
        s_tvalid <= 1'b0;
        while (pending_targets.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // APB write: setup then access; the model follows the register map
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_AMP0:  amp_reg[0]  = value[17:0] & AMP_MASK;
            REG_AMP1:  amp_reg[1]  = value[17:0] & AMP_MASK;
            REG_AMP2:  amp_reg[2]  = value[17:0] & AMP_MASK;
            REG_STEP0: step_reg[0] = value;
            REG_STEP1: step_reg[1] = value;
            REG_STEP2: step_reg[2] = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_joints(input logic [31:0] a0, input logic [31:0] a1,
                              input logic [31:0] a2, input logic [31:0] s0,
                              input logic [31:0] s1, input logic [31:0] s2);
        write_reg(REG_AMP0, a0);
        write_reg(REG_AMP1, a1);
        write_reg(REG_AMP2, a2);
        write_reg(REG_STEP0, s0);
        write_reg(REG_STEP1, s1);
        write_reg(REG_STEP2, s2);
    endtask

    // reset settings, plain motion, one tick that holds the phases
    task automatic test_default_motion();
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_quiet(SETTLE_CYCLES);
    endtask

    // quarter-turn steps land on the fold edges; amplitude with bits above the field
    task automatic test_quadrant_folds();
        set_joints(32'hFFFF_FFFF, 32'd0, 32'd131072,
                   32'h4000_0000, 32'h3FFF_FFFF, 32'h4000_0001);
        repeat (5) send_tick(1'b1);
        wait_quiet(SETTLE_CYCLES);
    endtask

    // largest and smallest steps, phase wrap, writes past the register map
    task automatic test_extreme_steps();
        set_joints(32'h3FFFF, 32'h3FFFF, 32'h3FFFF,
                   32'hFFFF_FFFF, 32'd0, 32'h8000_0000);
        write_reg(UNMAPPED_LO, $urandom());
        write_reg(UNMAPPED_HI, $urandom());
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        wait_quiet(SETTLE_CYCLES);
    endtask

    task automatic test_zero_amplitude();
        set_joints(32'd0, 32'd0, 32'd0, $urandom(), $urandom(), $urandom());
        repeat (3) send_tick(1'b1);
        wait_quiet(SETTLE_CYCLES);
    endtask

    // receiver holds off for a long stretch while ticks keep coming
    task automatic test_backpressure();
        set_joints($urandom(), $urandom(), $urandom(),
                   $urandom_range(0, 32'h0400_0000), $urandom(), $urandom());
        idle_on      <= 1'b0;
        hold_off_req <= ~hold_off_req;
        repeat (10) send_tick(1'b1);
        wait_quiet(SETTLE_CYCLES);
        idle_on <= 1'b1;
    endtask

    function automatic logic [31:0] pick_amp();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'h3FFFF;
            2:       return $urandom();
            default: return $urandom_range(0, 32'h3FFFF);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom();
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    // random settings, mostly advancing ticks; the last set runs without gaps
    task automatic test_random_settings();
        int k, n;
        for (k = 0; k < RANDOM_SETS; k++) begin
            if (k == RANDOM_SETS - 1) idle_on <= 1'b0;
            set_joints(pick_amp(), pick_amp(), pick_amp(),
                       pick_step(), pick_step(), pick_step());
            for (n = 0; n < TICKS_PER_SET; n++)
                send_tick($urandom_range(0, 9) != 0);
            wait_quiet(SETTLE_CYCLES);
        end
    endtask

    // receiver: random stall bursts, plus the long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left  = 0;
        end else if (hold_off_req != hold_off_seen) begin
            hold_off_seen = hold_off_req;
            stall_left    = LONG_HOLD;
            m_tready     <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result with the oldest queued prediction
    always @(posedge i_clk) begin
        logic [135:0] want;
        int           j;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_targets.size() == 0) begin
                report_mismatch("result with no tick outstanding");
            end else begin
                want = pending_targets.pop_front();
                for (j = 0; j < NUM_JOINTS; j++) begin
                    if (m_tdata[20*j +: 20] !== want[20*j +: 20])
                        report_mismatch($sformatf(
                            "item %0d position_joint%0d got %0d expected %0d",
                            results_seen, j, $signed(m_tdata[20*j +: 20]),
                            $signed(want[20*j +: 20])));
                    if (m_tdata[60 + 24*j +: 24] !== want[60 + 24*j +: 24])
                        report_mismatch($sformatf(
                            "item %0d velocity_joint%0d got %0d expected %0d",
                            results_seen, j, $signed(m_tdata[60 + 24*j +: 24]),
                            $signed(want[60 + 24*j +: 24])));
                end
            end
            results_seen++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_targets.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        amp_reg[0]   = 18'd25736;
        amp_reg[1]   = 18'd51472;
        amp_reg[2]   = 18'd51472;
        step_reg[0]  = 32'd2147484;
        step_reg[1]  = 32'd1431656;
        step_reg[2]  = 32'd1431656;
        phase_acc[0] = 32'd0;
        phase_acc[1] = 32'd0;
        phase_acc[2] = 32'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_motion();
        test_quadrant_folds();
        test_extreme_steps();
        test_zero_amplitude();
        test_backpressure();
        test_random_settings();
        wait_quiet(DRAIN_CYCLES);

        if (pending_targets.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_targets.size()));
        $display("covered %0d ticks (%0d holding phase), %0d results, %0d register writes",
                 ticks_sent, holds_sent, results_seen, reg_writes);
        $display("settings swept: reset values, fold edges, extreme steps and amplitudes, %s",
                 $sformatf("long receiver hold, %0d random sets", RANDOM_SETS));
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
